// ===== hdl/stj_pkg.sv =====
// ============================================================================
// stj_pkg
// Shared types and constants for the sparse triple join block: request and
// response payloads, the decoded command that crosses the internal queue.
// ============================================================================
package stj_pkg;

    // Coordinate width of every x, y and z field
    localparam int COORD_W = 6;
    // Rows held in each support bitmap (one per coordinate code)
    localparam int ROWS = 2 ** COORD_W;

    // Reported counter widths and saturating counter widths
    localparam int TRIP_W = 18;
    localparam int GROUP_W = 12;
    localparam int TRIP_CNT_W = TRIP_W + 1;
    localparam int GROUP_CNT_W = GROUP_W + 1;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    // Request type codes
    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_MARK_XY = 2'd1;
    localparam logic [1:0] REQ_MARK_XZ = 2'd2;
    localparam logic [1:0] REQ_ENUM = 2'd3;

    typedef enum logic [1:0] {
        OP_CLEAR,
        OP_MARK_XY,
        OP_MARK_XZ,
        OP_ENUM
    } op_t;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [COORD_W-1:0] pair_x;
        logic [COORD_W-1:0] coord_y;
        logic [COORD_W-1:0] coord_z;
    } req_t;

    typedef struct packed {
        logic               found;
        logic [COORD_W-1:0] trip_x;
        logic [COORD_W-1:0] trip_y;
        logic [COORD_W-1:0] trip_z;
        logic [TRIP_W-1:0]  triple_number;
        logic [GROUP_W-1:0] group_number;
        logic               group_start;
        logic               last;
    } rsp_t;

    typedef struct packed {
        op_t                op;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic               in_range;
    } cmd_t;

endpackage

// ===== hdl/stj_front.sv =====
// ============================================================================
// stj_front
// Request front end: decode each request, drop marks outside the table,
// flag enumerates outside the table, and queue commands for the back end.
// ============================================================================
module stj_front #(
    parameter int MAX_X = 64,
    parameter int MAX_Y = 64,
    parameter int MAX_Z = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  stj_pkg::req_t req,
    output logic          cmd_valid,
    input  logic          cmd_pop,
    output stj_pkg::cmd_t cmd
);

    localparam int QD = stj_pkg::QUEUE_DEPTH;
    localparam int PW = stj_pkg::QPTR_W;
    localparam int CW = PW + 1;

    localparam logic [6:0] X_LIM = 7'(MAX_X);
    localparam logic [8:0] Y_LIM = 9'(MAX_Y);
    localparam logic [8:0] Z_LIM = 9'(MAX_Z);

    stj_pkg::cmd_t q_mem [QD];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;

    stj_pkg::cmd_t dec;
    logic          x_ok;
    logic          y_ok;
    logic          z_ok;
    logic          keep;
    logic          push;
    logic          pop;

    // Classify the request
    always_comb
    begin
        x_ok = {1'b0, req.pair_x} < X_LIM;
        y_ok = {3'b000, req.coord_y} < Y_LIM;
        z_ok = {3'b000, req.coord_z} < Z_LIM;
        dec.x = req.pair_x;
        dec.y = req.coord_y;
        dec.z = req.coord_z;
        dec.in_range = y_ok && z_ok;
        unique case (req.req_type)
            stj_pkg::REQ_CLEAR:
            begin
                dec.op = stj_pkg::OP_CLEAR;
                keep = 1'b1;
            end
            stj_pkg::REQ_MARK_XY:
            begin
                dec.op = stj_pkg::OP_MARK_XY;
                keep = x_ok && y_ok;
            end
            stj_pkg::REQ_MARK_XZ:
            begin
                dec.op = stj_pkg::OP_MARK_XZ;
                keep = x_ok && z_ok;
            end
            default:
            begin
                dec.op = stj_pkg::OP_ENUM;
                keep = 1'b1;
            end
        endcase
    end

    assign req_stall = (count_reg == CW'(QD));
    assign push = req_valid && !req_stall && keep;
    assign pop = cmd_pop && cmd_valid;
    assign cmd_valid = (count_reg != '0);
    assign cmd = q_mem[rd_ptr_reg];

    // Store queued commands
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= dec;
        end
    end

    // Advance queue pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/stj_back.sv =====
// ============================================================================
// stj_back
// Command back end: holds both support bitmaps, applies clears and marks,
// and scans the joined row into the response register, one x per cycle unless stalled.
// ============================================================================
module stj_back #(
    parameter int MAX_X = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_pop,
    input  stj_pkg::cmd_t cmd,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output stj_pkg::rsp_t rsp
);

    localparam int ROWS = stj_pkg::ROWS;
    localparam int CW = stj_pkg::COORD_W;
    localparam int IDX_W = $clog2(MAX_X);
    localparam int TCW = stj_pkg::TRIP_CNT_W;
    localparam int GCW = stj_pkg::GROUP_CNT_W;
    localparam int TW = stj_pkg::TRIP_W;
    localparam int GW = stj_pkg::GROUP_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MARK,
        ST_LOAD,
        ST_SCAN
    } state_t;

    // Bitmap memories: row y (or z), bit x
    logic [MAX_X-1:0] xy_mem [ROWS];
    logic [MAX_X-1:0] xz_mem [ROWS];
    logic [ROWS-1:0]  xy_vld_reg;
    logic [ROWS-1:0]  xz_vld_reg;
    logic [MAX_X-1:0] xy_rd_reg;
    logic [MAX_X-1:0] xz_rd_reg;
    logic             xy_rd_vld_reg;
    logic             xz_rd_vld_reg;

    state_t              state_reg;
    stj_pkg::op_t        op_reg;
    logic [CW-1:0]       x_reg;
    logic [CW-1:0]       y_reg;
    logic [CW-1:0]       z_reg;
    logic                in_range_reg;
    logic [MAX_X-1:0]    hits_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic                empty_reg;
    logic                first_reg;
    logic [TCW-1:0]      trip_cnt_reg;
    logic [GCW-1:0]      group_cnt_reg;
    logic                rsp_valid_reg;
    stj_pkg::rsp_t       rsp_reg;

    logic [MAX_X-1:0]    xy_row;
    logic [MAX_X-1:0]    xz_row;
    logic [MAX_X-1:0]    mark_bit;
    logic                wr_xy;
    logic                wr_xz;
    logic                out_free;
    logic                rest_zero;
    logic                emit;
    logic                done;
    stj_pkg::rsp_t       rsp_next;

    assign xy_row = xy_rd_vld_reg ? xy_rd_reg : '0;
    assign xz_row = xz_rd_vld_reg ? xz_rd_reg : '0;
    assign mark_bit = {{(MAX_X-1){1'b0}}, 1'b1} << x_reg;
    assign wr_xy = (state_reg == ST_MARK) && (op_reg == stj_pkg::OP_MARK_XY);
    assign wr_xz = (state_reg == ST_MARK) && (op_reg == stj_pkg::OP_MARK_XZ);

    assign cmd_pop = (state_reg == ST_IDLE) && cmd_valid;
    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign rest_zero = (hits_reg[MAX_X-1:1] == '0);
    assign emit = (state_reg == ST_SCAN) && out_free && (empty_reg || hits_reg[0]);
    assign done = (state_reg == ST_SCAN) && out_free
                  && (empty_reg || (hits_reg[0] && rest_zero));

    // Build the next response
    always_comb
    begin
        rsp_next.found = !empty_reg;
        rsp_next.trip_x = empty_reg ? '0 : CW'(idx_reg);
        rsp_next.trip_y = y_reg;
        rsp_next.trip_z = z_reg;
        rsp_next.triple_number = empty_reg ? '0
                                 : (trip_cnt_reg[TCW-1] ? '1 : trip_cnt_reg[TW-1:0]);
        rsp_next.group_number = empty_reg ? '0
                                : (group_cnt_reg[GCW-1] ? '1 : group_cnt_reg[GW-1:0]);
        rsp_next.group_start = !empty_reg && first_reg;
        rsp_next.last = empty_reg || rest_zero;
    end

    // Read both bitmaps at the queue head, write back marks
    always_ff @(posedge clk)
    begin
        xy_rd_reg <= xy_mem[cmd.y];
        xz_rd_reg <= xz_mem[cmd.z];
        if (wr_xy)
        begin
            xy_mem[y_reg] <= xy_row | mark_bit;
        end
        if (wr_xz)
        begin
            xz_mem[z_reg] <= xz_row | mark_bit;
        end
    end

    // Hold scan payload and response payload
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            op_reg <= cmd.op;
            x_reg <= cmd.x;
            y_reg <= cmd.y;
            z_reg <= cmd.z;
            in_range_reg <= cmd.in_range;
        end
        if (state_reg == ST_LOAD)
        begin
            hits_reg <= xy_row & xz_row & {MAX_X{in_range_reg}};
        end
        else if ((state_reg == ST_SCAN) && out_free)
        begin
            hits_reg <= hits_reg >> 1;
        end
        if (emit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // Sequence commands, counters, row valid bits and response valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            xy_vld_reg <= '0;
            xz_vld_reg <= '0;
            xy_rd_vld_reg <= 1'b0;
            xz_rd_vld_reg <= 1'b0;
            idx_reg <= '0;
            empty_reg <= 1'b0;
            first_reg <= 1'b0;
            trip_cnt_reg <= '0;
            group_cnt_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            xy_rd_vld_reg <= xy_vld_reg[cmd.y];
            xz_rd_vld_reg <= xz_vld_reg[cmd.z];
            if (out_free)
            begin
                rsp_valid_reg <= emit;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        unique case (cmd.op)
                            stj_pkg::OP_CLEAR:
                            begin
                                xy_vld_reg <= '0;
                                xz_vld_reg <= '0;
                                trip_cnt_reg <= '0;
                                group_cnt_reg <= '0;
                            end
                            stj_pkg::OP_ENUM:
                            begin
                                state_reg <= ST_LOAD;
                            end
                            default:
                            begin
                                state_reg <= ST_MARK;
                            end
                        endcase
                    end
                end
                ST_MARK:
                begin
                    if (wr_xy)
                    begin
                        xy_vld_reg[y_reg] <= 1'b1;
                    end
                    if (wr_xz)
                    begin
                        xz_vld_reg[z_reg] <= 1'b1;
                    end
                    state_reg <= ST_IDLE;
                end
                ST_LOAD:
                begin
                    idx_reg <= '0;
                    first_reg <= 1'b1;
                    empty_reg <= ((xy_row & xz_row & {MAX_X{in_range_reg}}) == '0);
                    state_reg <= ST_SCAN;
                end
                default:
                begin
                    if (out_free)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    if (emit && !empty_reg)
                    begin
                        first_reg <= 1'b0;
                        if (!trip_cnt_reg[TCW-1])
                        begin
                            trip_cnt_reg <= trip_cnt_reg + 1'b1;
                        end
                    end
                    if (done)
                    begin
                        if (!empty_reg && !group_cnt_reg[GCW-1])
                        begin
                            group_cnt_reg <= group_cnt_reg + 1'b1;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp = rsp_reg;

endmodule

// ===== hdl/sparse_triple_join_core.sv =====
// ============================================================================
// sparse_triple_join_core
// Support-set join over (x,y) and (x,z) bitmaps for a three-way table.
// ============================================================================
// Usage:
//   req channel (req_valid / req_stall / req): clear, mark (x,y), mark (x,z)
//   or enumerate (y,z). A transfer happens when req_valid is high and
//   req_stall is low. Requests go through a four-entry command queue, so the
//   front keeps taking transfers while the back end works.
//   rsp channel (rsp_valid / rsp_stall / rsp): one response per joined x in
//   ascending order, or a single response with found low for an empty join;
//   last marks the final response of each enumerate.
// Sequencing, set by the back end that handles one command at a time:
//   a clear is done at once in idle, a mark reads the bitmap then writes it,
//   and an enumerate loads the joined row then scans it from x = 0, giving a
//   response for each joined x and waiting while rsp_stall holds the output.
// Reset: clears queue, counters and both bitmaps at once (row valid bits).
// A stalled response holds in the output register; the scan waits for it,
// and the queue raises req_stall once four commands are waiting.
// ============================================================================
module sparse_triple_join_core #(
    parameter int MAX_X = 64,
    parameter int MAX_Y = 64,
    parameter int MAX_Z = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  stj_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output stj_pkg::rsp_t rsp
);

    logic          cmd_valid;
    logic          cmd_pop;
    stj_pkg::cmd_t cmd;

    // Decode and queue requests
    stj_front #(
        .MAX_X(MAX_X),
        .MAX_Y(MAX_Y),
        .MAX_Z(MAX_Z)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .cmd_valid(cmd_valid),
        .cmd_pop(cmd_pop),
        .cmd(cmd)
    );

    // Execute commands and drive responses
    stj_back #(
        .MAX_X(MAX_X)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .cmd_valid(cmd_valid),
        .cmd_pop(cmd_pop),
        .cmd(cmd),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp)
    );

endmodule

// ===== hdl/stj_checker.sv =====
// ============================================================================
// stj_checker
// Port-level checks for the sparse triple join block, bound to the top level.
// ============================================================================
module stj_checker #(
    parameter int MAX_X = 64
) (
    input logic          clk,
    input logic          rst_n,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input stj_pkg::rsp_t rsp
);

    // Hold a stalled response
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled response changed or dropped");

    // An empty join is a single, final, unnumbered response
    a_empty_shape: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.found |-> rsp.last && !rsp.group_start
            && rsp.triple_number == '0 && rsp.group_number == '0 && rsp.trip_x == '0)
        else $error("empty join response malformed");

    // Group start only on a joined triple
    a_start_found: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.group_start |-> rsp.found)
        else $error("group start without a triple");

    // Joined x lies inside the table
    a_x_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.found |-> {1'b0, rsp.trip_x} < 7'(MAX_X))
        else $error("joined x out of range");

endmodule

bind sparse_triple_join_core stj_checker #(
    .MAX_X(MAX_X)
) u_stj_checker (
    .clk(clk),
    .rst_n(rst_n),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
);
